// ----- rtl/ecp_pkg.sv -----
// Shared types, codes and constants of the Euler-angle camera pose unit.
`timescale 1ns / 1ps
package ecp_pkg;

    // Command kinds carried in the input tuser.
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LOOK = 1'b1;

    // Move directions.
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_MOUSE_SENS = 3'd0;
    localparam logic [2:0] REG_MOVE_SPEED = 3'd1;
    localparam logic [2:0] REG_CONSTRAIN  = 3'd2;
    localparam logic [2:0] REG_WORLD_UP_X = 3'd3;
    localparam logic [2:0] REG_WORLD_UP_Y = 3'd4;
    localparam logic [2:0] REG_WORLD_UP_Z = 3'd5;

    // Angles are degrees in Q9.16.
    localparam logic signed [25:0] DEG90  = 26'sd5898240;
    localparam logic signed [34:0] DEG89  = 35'sd5832704;
    localparam logic signed [34:0] DEG180 = 35'sd11796480;
    localparam logic [33:0] FULL_TURN     = 34'd23592960;
    // 128 full turns keep every sum that enters the reducer positive.
    localparam logic signed [34:0] WRAP_BIAS = 35'sd3019898880;
    localparam int unsigned WRAP_STEPS = 8;

    localparam logic signed [34:0] PITCH_MAX = 35'sd33554431;
    localparam logic signed [34:0] PITCH_MIN = -35'sd33554432;

    // CORDIC gain-compensated start value in Q30 and arctangent table in Q16 degrees.
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;
    localparam int unsigned ATAN_DEPTH = 24;
    localparam logic [21:0] ATAN_DEG_Q16 [ATAN_DEPTH] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    localparam logic signed [15:0] UNIT_ONE = 16'sd16384;

endpackage

// ----- rtl/ecp_cordic.sv -----
// Iterative CORDIC unit returning sine and cosine of an angle in degrees.
`timescale 1ns / 1ps
module ecp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [25:0] angle,
    output logic               busy,
    output logic signed [31:0] sin_out,
    output logic signed [31:0] cos_out
);
    import ecp_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_RUN  = 2'b10
    } cordic_state_t;

    cordic_state_t state_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [27:0] z_reg;
    logic               neg_reg;
    logic [4:0]         i_reg;
    logic signed [33:0] x_sh, y_sh, neg_x, neg_y;
    logic signed [27:0] atan_val;

    assign x_sh     = x_reg >>> i_reg;
    assign y_sh     = y_reg >>> i_reg;
    assign atan_val = $signed({6'b0, ATAN_DEG_Q16[i_reg]});
    assign busy     = (state_reg == C_RUN);
    assign neg_x    = -x_reg;
    assign neg_y    = -y_reg;
    assign sin_out  = neg_reg ? neg_y[31:0] : y_reg[31:0];
    assign cos_out  = neg_reg ? neg_x[31:0] : x_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        state_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == C_IDLE && start) begin
            x_reg <= CORDIC_X0;
            y_reg <= '0;
            i_reg <= '0;
            // Fold the half-turn outside +-90 degrees back in and flip both results.
            if (angle > DEG90) begin
                z_reg   <= 28'(angle) - 28'(DEG180);
                neg_reg <= 1'b1;
            end else if (angle < -DEG90) begin
                z_reg   <= 28'(angle) + 28'(DEG180);
                neg_reg <= 1'b1;
            end else begin
                z_reg   <= 28'(angle);
                neg_reg <= 1'b0;
            end
        end else if (state_reg == C_RUN) begin
            i_reg <= i_reg + 5'd1;
            if (!z_reg[27]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end
        end
    end

endmodule

// ----- rtl/ecp_norm.sv -----
// Vector normalizer: sum of squares, bit-serial square root and per-component division.
`timescale 1ns / 1ps
module ecp_norm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] vec_in [3],
    output logic               busy,
    output logic signed [15:0] unit_out [3]
);
    import ecp_pkg::*;

    typedef enum logic [4:0] {
        N_IDLE = 5'b00001,
        N_SQ   = 5'b00010,
        N_CHK  = 5'b00100,
        N_ROOT = 5'b01000,
        N_DIV  = 5'b10000
    } norm_state_t;

    norm_state_t state_reg;
    logic [31:0] mag_reg [3];
    logic        neg_reg [3];
    logic [63:0] sq_reg, acc_reg;
    logic [63:0] rv_reg, r_reg, b_reg;
    logic [31:0] s_reg;
    logic [47:0] rem_reg;
    logic [15:0] q_reg;
    logic [3:0]  j_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic        load_reg;

    logic [1:0]  sq_idx;
    logic [63:0] rb_sum;
    logic [47:0] den_sh;
    logic [15:0] q_next;
    logic [15:0] q_cap;
    logic [47:0] rem_init;

    assign busy     = (state_reg != N_IDLE);
    assign sq_idx   = (cnt_reg == 2'd3) ? 2'd0 : cnt_reg;
    assign rb_sum   = r_reg + b_reg;
    assign den_sh   = {16'b0, s_reg} << j_reg;
    assign rem_init = {2'b0, mag_reg[comp_reg], 14'b0} + {17'b0, s_reg[31:1]};
    assign q_next   = (rem_reg >= den_sh) ? (q_reg | (16'd1 << j_reg)) : q_reg;
    assign q_cap    = (q_next > 16'(UNIT_ONE)) ? 16'(UNIT_ONE) : q_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            case (state_reg)
                N_IDLE: if (start) state_reg <= N_SQ;
                N_SQ:   if (cnt_reg == 2'd3) state_reg <= N_CHK;
                N_CHK:  state_reg <= (acc_reg == '0) ? N_IDLE : N_ROOT;
                N_ROOT: if (b_reg == 64'd1) state_reg <= N_DIV;
                N_DIV: begin
                    if (!load_reg && j_reg == 4'd0 && comp_reg == 2'd2) begin
                        state_reg <= N_IDLE;
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    for (int k = 0; k < 3; k++) begin
                        neg_reg[k] <= vec_in[k][31];
                        mag_reg[k] <= vec_in[k][31] ? (~vec_in[k] + 32'd1) : vec_in[k];
                    end
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            N_SQ: begin
                sq_reg  <= mag_reg[sq_idx] * mag_reg[sq_idx];
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg != 2'd0) begin
                    acc_reg <= acc_reg + sq_reg;
                end
            end
            N_CHK: begin
                rv_reg <= acc_reg;
                r_reg  <= '0;
                b_reg  <= 64'd1 << 62;
                if (acc_reg == '0) begin
                    for (int k = 0; k < 3; k++) unit_out[k] <= '0;
                end
            end
            N_ROOT: begin
                if (rv_reg >= rb_sum) begin
                    rv_reg <= rv_reg - rb_sum;
                    r_reg  <= (r_reg >> 1) + b_reg;
                    s_reg  <= 32'((r_reg >> 1) + b_reg);
                end else begin
                    r_reg <= r_reg >> 1;
                    s_reg <= 32'(r_reg >> 1);
                end
                b_reg    <= b_reg >> 2;
                comp_reg <= '0;
                load_reg <= 1'b1;
            end
            N_DIV: begin
                if (load_reg) begin
                    rem_reg  <= rem_init;
                    q_reg    <= '0;
                    j_reg    <= 4'd15;
                    load_reg <= 1'b0;
                end else begin
                    if (rem_reg >= den_sh) rem_reg <= rem_reg - den_sh;
                    q_reg <= q_next;
                    j_reg <= j_reg - 4'd1;
                    if (j_reg == 4'd0) begin
                        unit_out[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_cap)
                                                                : $signed(q_cap);
                        comp_reg <= comp_reg + 2'd1;
                        load_reg <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/euler_camera_pose_update_unit.sv -----
// Top level of the Euler-angle fly camera pose unit with its sequencer and shared multiplier.
`timescale 1ns / 1ps
// The unit holds a camera position (Q16.16), yaw and pitch (degrees, Q9.16) and the front,
// right and up unit vectors (Q2.14), and returns the position and the three unit vectors
// after every input transfer. A move command (tuser 0) shifts the position along one of six
// directions by speed times delta time with saturation, using the shared multiplier that
// does one product per cycle. A look command (tuser 1) updates yaw and pitch, rebuilds front
// with a CORDIC unit, then right and up as normalized cross products; its time goes mostly
// to the three normalizer passes (each a 32-step square root and three divisions). Only one
// command is in flight: s_tready is high while the sequencer is idle, and a finished result
// waits in its own output register so the next command can be accepted meanwhile.
// Configuration writes are always accepted and must only happen while the unit is idle;
// a new world-up vector takes effect at the next look command.
module euler_camera_pose_update_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: direction[2:0], delta_time[18:3], x_offset[34:19],
    // y_offset[50:35], zero fill[55:51].
    input  logic [55:0]  s_tdata,
    // Fields from bit 0: command[0].
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: pos_x, pos_y, pos_z (32 bits each), then front_x, front_y,
    // front_z, right_x, right_y, right_z, up_x, up_y, up_z (16 bits each).
    output logic [239:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import ecp_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_MVEL = 19'b0000000000000000010,
        S_MLAT = 19'b0000000000000000100,
        S_MAX  = 19'b0000000000000001000,
        S_LDX  = 19'b0000000000000010000,
        S_LDY  = 19'b0000000000000100000,
        S_LP   = 19'b0000000000001000000,
        S_WRY  = 19'b0000000000010000000,
        S_YSET = 19'b0000000000100000000,
        S_WRP  = 19'b0000000001000000000,
        S_CYW  = 19'b0000000010000000000,
        S_CPW  = 19'b0000000100000000000,
        S_FM   = 19'b0000001000000000000,
        S_NF   = 19'b0000010000000000000,
        S_CR   = 19'b0000100000000000000,
        S_NR   = 19'b0001000000000000000,
        S_CU   = 19'b0010000000000000000,
        S_NU   = 19'b0100000000000000000,
        S_FIN  = 19'b1000000000000000000
    } seq_state_t;

    seq_state_t state_reg;

    // Configuration registers.
    logic [15:0]        sens_reg, speed_reg;
    logic               constrain_reg;
    logic signed [15:0] wu_reg [3];

    // Camera state.
    logic signed [31:0] pos_reg [3];
    logic signed [25:0] yaw_reg, pitch_reg;
    logic signed [15:0] front_reg [3], right_reg [3], up_reg [3];

    // Latched command fields and working registers.
    logic [2:0]         dir_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] xoff_reg, yoff_reg;
    logic [31:0]        vel_reg;
    logic signed [64:0] prod_reg;
    logic [2:0]         cnt_reg;
    logic [33:0]        wrap_reg;
    logic signed [31:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [31:0] vec_reg [3];
    logic               m_tvalid_reg;
    logic [239:0]       m_tdata_reg;

    // Shared multiplier operands.
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;

    // Move datapath.
    logic signed [15:0] axis_sel [3];
    logic               axis_valid, axis_sub;
    logic [1:0]         mv_idx, mv_wb;
    logic signed [64:0] rnd_sum;
    logic signed [33:0] step_d, pos_ext, pos_new;
    logic signed [31:0] pos_sat;

    // Look datapath.
    logic signed [34:0] yaw_load, pitch_load, pitch_sum, pitch_clamp;
    logic [33:0]        wrap_sub;
    logic [33:0]        wrap_res;
    logic signed [25:0] wrap_angle;

    // Cross product datapath.
    logic signed [15:0] cr_a [3], cr_b [3];
    logic [1:0]         cr_comp, cr_wb_comp, cr_i1, cr_i2;
    logic [2:0]         cr_wb;

    logic               cordic_start, cordic_busy;
    logic signed [31:0] cordic_sin, cordic_cos;
    logic               norm_start, norm_busy;
    logic signed [15:0] norm_unit [3];
    logic               out_load;

    function automatic logic [1:0] rot3(input logic [1:0] k, input logic [1:0] n);
        logic [2:0] s;
        s = {1'b0, k} + {1'b0, n};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    // Axis and sense of a move.
    always_comb begin
        axis_valid = 1'b1;
        axis_sub   = 1'b0;
        axis_sel   = front_reg;
        case (dir_reg)
            DIR_FWD:   axis_sel = front_reg;
            DIR_BACK:  begin axis_sel = front_reg; axis_sub = 1'b1; end
            DIR_LEFT:  begin axis_sel = right_reg; axis_sub = 1'b1; end
            DIR_RIGHT: axis_sel = right_reg;
            DIR_UP:    axis_sel = up_reg;
            DIR_DOWN:  begin axis_sel = up_reg; axis_sub = 1'b1; end
            default:   axis_valid = 1'b0;
        endcase
    end

    assign mv_idx  = (cnt_reg >= 3'd3) ? 2'd0 : cnt_reg[1:0];
    assign mv_wb   = (cnt_reg == 3'd0) ? 2'd0 : 2'(cnt_reg - 3'd1);
    // Round the Q8.24 step scaled by a Q2.14 axis to Q16.16, with halves rounding up.
    assign rnd_sum = prod_reg + 65'sd2097152;
    assign step_d  = rnd_sum[55:22];
    assign pos_ext = 34'(pos_reg[mv_wb]);
    assign pos_new = axis_sub ? (pos_ext - step_d) : (pos_ext + step_d);
    always_comb begin
        if (pos_new > 34'sd2147483647) begin
            pos_sat = 32'sh7fffffff;
        end else if (pos_new < -34'sd2147483648) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = pos_new[31:0];
        end
    end

    // Angle update and the turn reducer.
    assign yaw_load   = 35'(yaw_reg) + prod_reg[34:0] + DEG180 + WRAP_BIAS;
    assign pitch_load = 35'(pitch_reg) + DEG180 + WRAP_BIAS;
    assign pitch_sum  = 35'(pitch_reg) + prod_reg[34:0];
    always_comb begin
        pitch_clamp = pitch_sum;
        if (constrain_reg) begin
            if (pitch_clamp > DEG89) pitch_clamp = DEG89;
            if (pitch_clamp < -DEG89) pitch_clamp = -DEG89;
        end
        if (pitch_clamp > PITCH_MAX) pitch_clamp = PITCH_MAX;
        if (pitch_clamp < PITCH_MIN) pitch_clamp = PITCH_MIN;
    end
    assign wrap_sub   = FULL_TURN << (3'(WRAP_STEPS - 1) - cnt_reg);
    assign wrap_res   = wrap_reg - 34'(DEG180);
    assign wrap_angle = wrap_res[25:0];

    // Cross product operand selection: the first product of a component is issued on
    // an even count, the subtracted one on the odd count after it.
    assign cr_a       = (state_reg == S_CR) ? front_reg : right_reg;
    assign cr_b       = (state_reg == S_CR) ? wu_reg : front_reg;
    assign cr_comp    = (cnt_reg[2:1] == 2'd3) ? 2'd0 : cnt_reg[2:1];
    assign cr_i1      = rot3(cr_comp, cnt_reg[0] ? 2'd2 : 2'd1);
    assign cr_i2      = rot3(cr_comp, cnt_reg[0] ? 2'd1 : 2'd2);
    assign cr_wb      = cnt_reg - 3'd1;
    assign cr_wb_comp = (cr_wb[2:1] == 2'd3) ? 2'd0 : cr_wb[2:1];

    assign cordic_start = (state_reg == S_YSET) || (state_reg == S_CYW && !cordic_busy);
    assign norm_start   = ((state_reg == S_FM || state_reg == S_CR || state_reg == S_CU)
                           && cnt_reg == 3'd7);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MVEL: begin
                mul_a = $signed({16'b0, speed_reg});
                mul_b = $signed({17'b0, dt_reg});
            end
            S_MAX: begin
                mul_a = 32'(axis_sel[mv_idx]);
                mul_b = $signed({1'b0, vel_reg});
            end
            S_LDX: begin
                mul_a = 32'(xoff_reg);
                mul_b = $signed({17'b0, sens_reg});
            end
            S_LDY: begin
                mul_a = 32'(yoff_reg);
                mul_b = $signed({17'b0, sens_reg});
            end
            S_FM: begin
                mul_a = (cnt_reg == 3'd0) ? cy_reg : sy_reg;
                mul_b = 33'(cp_reg);
            end
            S_CR, S_CU: begin
                mul_a = 32'(cr_a[cr_i1]);
                mul_b = 33'(cr_b[cr_i2]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg      <= 16'd6554;
            speed_reg     <= 16'd640;
            constrain_reg <= 1'b1;
            wu_reg[0]     <= '0;
            wu_reg[1]     <= UNIT_ONE;
            wu_reg[2]     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MOUSE_SENS: sens_reg      <= cfg_data;
                REG_MOVE_SPEED: speed_reg     <= cfg_data;
                REG_CONSTRAIN:  constrain_reg <= cfg_data[0];
                REG_WORLD_UP_X: wu_reg[0]     <= $signed(cfg_data);
                REG_WORLD_UP_Y: wu_reg[1]     <= $signed(cfg_data);
                REG_WORLD_UP_Z: wu_reg[2]     <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer and camera state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            for (int k = 0; k < 3; k++) pos_reg[k] <= '0;
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            front_reg[0] <= UNIT_ONE; front_reg[1] <= '0; front_reg[2] <= '0;
            right_reg[0] <= '0; right_reg[1] <= '0; right_reg[2] <= UNIT_ONE;
            up_reg[0]    <= '0; up_reg[1] <= UNIT_ONE; up_reg[2] <= '0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= (s_tuser == CMD_LOOK) ? S_LDX : S_MVEL;
                    end
                end
                S_MVEL: state_reg <= S_MLAT;
                S_MLAT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_MAX;
                end
                S_MAX: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0 && axis_valid) pos_reg[mv_wb] <= pos_sat;
                    if (cnt_reg == 3'd3) state_reg <= S_FIN;
                end
                S_LDX: state_reg <= S_LDY;
                S_LDY: state_reg <= S_LP;
                S_LP: begin
                    pitch_reg <= pitch_clamp[25:0];
                    cnt_reg   <= '0;
                    state_reg <= S_WRY;
                end
                S_WRY: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'(WRAP_STEPS - 1)) state_reg <= S_YSET;
                end
                S_YSET: begin
                    yaw_reg   <= wrap_angle;
                    cnt_reg   <= '0;
                    state_reg <= S_WRP;
                end
                S_WRP: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'(WRAP_STEPS - 1)) state_reg <= S_CYW;
                end
                S_CYW: if (!cordic_busy) state_reg <= S_CPW;
                S_CPW: begin
                    if (!cordic_busy) begin
                        cnt_reg   <= '0;
                        state_reg <= S_FM;
                    end
                end
                S_FM: begin
                    cnt_reg <= (cnt_reg == 3'd2) ? 3'd7 : cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) state_reg <= S_NF;
                end
                S_NF: begin
                    if (!norm_busy) begin
                        front_reg <= norm_unit;
                        cnt_reg   <= '0;
                        state_reg <= S_CR;
                    end
                end
                S_CR: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) state_reg <= S_NR;
                end
                S_NR: begin
                    if (!norm_busy) begin
                        right_reg <= norm_unit;
                        cnt_reg   <= '0;
                        state_reg <= S_CU;
                    end
                end
                S_CU: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) state_reg <= S_NU;
                end
                S_NU: begin
                    if (!norm_busy) begin
                        up_reg    <= norm_unit;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: if (out_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Working registers without reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dir_reg  <= s_tdata[2:0];
                    dt_reg   <= s_tdata[18:3];
                    xoff_reg <= $signed(s_tdata[34:19]);
                    yoff_reg <= $signed(s_tdata[50:35]);
                end
            end
            S_MLAT: vel_reg <= prod_reg[31:0];
            S_LDY:  wrap_reg <= yaw_load[33:0];
            S_WRY, S_WRP: begin
                if (wrap_reg >= wrap_sub) wrap_reg <= wrap_reg - wrap_sub;
            end
            S_YSET: wrap_reg <= pitch_load[33:0];
            S_CYW: begin
                if (!cordic_busy) begin
                    sy_reg <= cordic_sin;
                    cy_reg <= cordic_cos;
                end
            end
            S_CPW: begin
                if (!cordic_busy) begin
                    sp_reg <= cordic_sin;
                    cp_reg <= cordic_cos;
                end
            end
            S_FM: begin
                if (cnt_reg == 3'd1) vec_reg[0] <= prod_reg[61:30];
                if (cnt_reg == 3'd2) begin
                    vec_reg[2] <= prod_reg[61:30];
                    vec_reg[1] <= sp_reg;
                end
            end
            S_CR, S_CU: begin
                if (cnt_reg != 3'd0 && cnt_reg != 3'd7) begin
                    if (!cr_wb[0]) begin
                        vec_reg[cr_wb_comp] <= prod_reg[31:0];
                    end else begin
                        vec_reg[cr_wb_comp] <= vec_reg[cr_wb_comp] - prod_reg[31:0];
                    end
                end
            end
            default: ;
        endcase

        if (out_load) begin
            m_tdata_reg <= {up_reg[2], up_reg[1], up_reg[0],
                            right_reg[2], right_reg[1], right_reg[0],
                            front_reg[2], front_reg[1], front_reg[0],
                            pos_reg[2], pos_reg[1], pos_reg[0]};
        end
    end

    ecp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (wrap_angle),
        .busy    (cordic_busy),
        .sin_out (cordic_sin),
        .cos_out (cordic_cos)
    );

    ecp_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (norm_start),
        .vec_in   (vec_reg),
        .busy     (norm_busy),
        .unit_out (norm_unit)
    );

endmodule

// ----- tb/ecp_checker.sv -----
// Pose predictor and result comparator for the Euler-angle camera pose unit.
`timescale 1ns / 1ps
module ecp_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [55:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [239:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           mismatches,
    output int           poses_pending
);
    import ecp_pkg::*;

    typedef longint vec3_t [3];

    longint sens, speed, clamp_on;
    vec3_t  world_up, cam_pos, front_u, right_u, up_u;
    longint yaw_deg, pitch_deg;
    logic [239:0] pose_q [$];

    string field_name [12] = '{"pos_x", "pos_y", "pos_z", "front_x", "front_y", "front_z",
                               "right_x", "right_y", "right_z", "up_x", "up_y", "up_z"};

    function automatic longint wrap_deg(input longint a);
        longint r;
        r = (a + longint'(DEG180)) % longint'(FULL_TURN);
        if (r < 0) r += longint'(FULL_TURN);
        return r - longint'(DEG180);
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, t;
        bit flip;
        z = wrap_deg(ang);
        x = 652032875;
        y = 0;
        flip = 0;
        if (z > longint'(DEG90)) begin
            z -= longint'(DEG180);
            flip = 1;
        end else if (z < -longint'(DEG90)) begin
            z += longint'(DEG180);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z -= longint'(ATAN_DEG_Q16[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z += longint'(ATAN_DEG_Q16[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void to_unit(input vec3_t v, output vec3_t o);
        longint unsigned sum, len, q, m;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            m = (v[k] < 0) ? -v[k] : v[k];
            sum += m * m;
        end
        for (int k = 0; k < 3; k++) o[k] = 0;
        if (sum != 0) begin
            len = int_sqrt(sum);
            for (int k = 0; k < 3; k++) begin
                m = (v[k] < 0) ? -v[k] : v[k];
                q = (m * 16384 + len / 2) / len;
                if (q > 16384) q = 16384;
                o[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    task automatic rebuild_axes();
        longint sy, cy, sp, cp;
        vec3_t raw;
        sin_cos(yaw_deg, sy, cy);
        sin_cos(pitch_deg, sp, cp);
        raw[0] = (cy * cp) >>> 30;
        raw[1] = sp;
        raw[2] = (sy * cp) >>> 30;
        to_unit(raw, front_u);
        cross3(front_u, world_up, raw);
        to_unit(raw, right_u);
        cross3(right_u, front_u, raw);
        to_unit(raw, up_u);
    endtask

    task automatic shift_pos(input vec3_t axis, input bit back, input longint vel);
        longint d, p;
        for (int k = 0; k < 3; k++) begin
            d = (axis[k] * vel + (longint'(1) << 21)) >>> 22;
            p = back ? cam_pos[k] - d : cam_pos[k] + d;
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            cam_pos[k] = p;
        end
    endtask

    // Applies one accepted command and returns the packed pose that must follow it.
    task automatic next_pose(input logic cmd, input logic [55:0] d, output logic [239:0] pose);
        longint vel, p;
        if (cmd == CMD_MOVE) begin
            vel = speed * longint'(d[18:3]);
            case (d[2:0])
                DIR_FWD:   shift_pos(front_u, 0, vel);
                DIR_BACK:  shift_pos(front_u, 1, vel);
                DIR_LEFT:  shift_pos(right_u, 1, vel);
                DIR_RIGHT: shift_pos(right_u, 0, vel);
                DIR_UP:    shift_pos(up_u, 0, vel);
                DIR_DOWN:  shift_pos(up_u, 1, vel);
                default: ;
            endcase
        end else begin
            p = pitch_deg + longint'($signed(d[50:35])) * sens;
            yaw_deg = wrap_deg(yaw_deg + longint'($signed(d[34:19])) * sens);
            if (clamp_on != 0) begin
                if (p > longint'(DEG89)) p = longint'(DEG89);
                if (p < -longint'(DEG89)) p = -longint'(DEG89);
            end
            if (p > longint'(PITCH_MAX)) p = longint'(PITCH_MAX);
            if (p < longint'(PITCH_MIN)) p = longint'(PITCH_MIN);
            pitch_deg = p;
            rebuild_axes();
        end
        for (int k = 0; k < 3; k++) begin
            pose[k*32 +: 32]      = cam_pos[k][31:0];
            pose[96 + k*16 +: 16]  = front_u[k][15:0];
            pose[144 + k*16 +: 16] = right_u[k][15:0];
            pose[192 + k*16 +: 16] = up_u[k][15:0];
        end
    endtask

    task automatic compare_pose(input logic [239:0] want, input logic [239:0] got);
        logic [31:0] w, g;
        for (int k = 0; k < 12; k++) begin
            w = (k < 3) ? want[k*32 +: 32] : {16'd0, want[96 + (k-3)*16 +: 16]};
            g = (k < 3) ? got[k*32 +: 32]  : {16'd0, got[96 + (k-3)*16 +: 16]};
            if (w != g) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s expected %h got %h", $realtime, field_name[k], w, g);
            end
        end
    endtask

    always @(posedge aclk) begin
        logic [239:0] pose;
        if (!aresetn) begin
            sens = 6554;
            speed = 640;
            clamp_on = 1;
            world_up = '{0, 16384, 0};
            cam_pos = '{0, 0, 0};
            yaw_deg = 0;
            pitch_deg = 0;
            front_u = '{16384, 0, 0};
            right_u = '{0, 0, 16384};
            up_u = '{0, 16384, 0};
            pose_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MOUSE_SENS: sens = longint'(cfg_data);
                    REG_MOVE_SPEED: speed = longint'(cfg_data);
                    REG_CONSTRAIN:  clamp_on = longint'(cfg_data[0]);
                    REG_WORLD_UP_X: world_up[0] = longint'($signed(cfg_data));
                    REG_WORLD_UP_Y: world_up[1] = longint'($signed(cfg_data));
                    REG_WORLD_UP_Z: world_up[2] = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with no pose expected", $realtime);
                end else begin
                    compare_pose(pose_q.pop_front(), m_tdata);
                end
            end
            if (s_tvalid && s_tready) begin
                next_pose(s_tuser, s_tdata, pose);
                pose_q.push_back(pose);
            end
        end
        poses_pending = pose_q.size();
    end

endmodule

// ----- tb/tb_euler_camera_pose_update_unit.sv -----
// Stimulus, handshake pacing and verdict for the camera pose unit testbench.
`timescale 1ns / 1ps
module tb_euler_camera_pose_update_unit;
    import ecp_pkg::*;

    // A result may wait on a long look command and on a stalled receiver, so only a stretch
    // without any transfer that reaches STALL_LIMIT means the unit hung.
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 400;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [239:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    int mismatches;
    int poses_pending;
    int quiet_cycles = 0;
    // While set, neither side inserts idle cycles.
    bit steady = 0;

    always #5 aclk = ~aclk;

    euler_camera_pose_update_unit dut (.*);

    ecp_checker pose_check (.*);

    // The receiver holds back about one cycle in five, except during steady stretches.
    always @(negedge aclk) m_tready = steady || ($urandom_range(99) >= 21);

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one command. Move and look fill the fields that a command ignores with random bits.
    task automatic send_cmd(input logic cmd, input logic [2:0] dir, input logic [15:0] dt,
                            input logic [15:0] xo, input logic [15:0] yo);
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {5'd0, yo, xo, dt, dir};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_poses();
        s_tvalid = 0;
        while (poses_pending != 0) @(negedge aclk);
    endtask

    // Register writes only happen once every pose of the previous phase has arrived.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        drain_poses();
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic set_world_up(input logic [15:0] ux, input logic [15:0] uy,
                                input logic [15:0] uz);
        write_reg(REG_WORLD_UP_X, ux);
        write_reg(REG_WORLD_UP_Y, uy);
        write_reg(REG_WORLD_UP_Z, uz);
    endtask

    task automatic move(input logic [2:0] dir, input logic [15:0] dt);
        send_cmd(CMD_MOVE, dir, dt, 16'($urandom), 16'($urandom));
    endtask

    task automatic look(input logic [15:0] xo, input logic [15:0] yo);
        send_cmd(CMD_LOOK, 3'($urandom), 16'($urandom), xo, yo);
    endtask

    // Random commands for one phase. drift_bias pushes moves toward forward with long
    // time steps so that the position walks into saturation.
    task automatic random_phase(input int count, input int look_pct, input bit drift_bias);
        logic [2:0] dir;
        logic [15:0] dt;
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 3) && (n < count / 3 + 60);
            if ($urandom_range(99) < look_pct) begin
                case ($urandom_range(3))
                    0: look(16'($urandom_range(20) - 10), 16'($urandom_range(20) - 10));
                    1: look(16'($urandom), 16'($urandom));
                    default: look(16'($urandom_range(400) - 200),
                                  16'($urandom_range(400) - 200));
                endcase
            end else begin
                dir = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
                dt = 16'($urandom);
                if (drift_bias && $urandom_range(9) < 7) begin
                    dir = DIR_FWD;
                    dt = 16'hffff;
                end
                move(dir, dt);
            end
            // At least once the sender waits for every pose before going on.
            if (n == count / 2) drain_poses();
        end
        steady = 0;
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1;

        // Directed part: reset pose, each direction, unused directions and field extremes.
        move(DIR_FWD, 16'hffff);
        move(DIR_BACK, 16'd0);
        move(DIR_LEFT, 16'h8000);
        move(DIR_RIGHT, 16'hffff);
        move(DIR_UP, 16'h0001);
        move(DIR_DOWN, 16'hffff);
        move(3'd6, 16'hffff);
        move(3'd7, 16'hffff);
        look(16'h0000, 16'h0000);
        look(16'h7fff, 16'h7fff);
        look(16'h8000, 16'h8000);
        look(16'd900, 16'hffff);
        move(DIR_FWD, 16'hffff);
        move(DIR_RIGHT, 16'hffff);
        move(DIR_UP, 16'hffff);

        // Zero sensitivity keeps yaw and pitch while the world up turns to the x axis.
        write_reg(REG_MOUSE_SENS, 16'd0);
        set_world_up(16'sd16384, 16'sd0, 16'sd0);
        look(16'd0, 16'd0);
        move(DIR_RIGHT, 16'hffff);
        // A zero world up vector leaves right and up as zero vectors.
        set_world_up(16'sd0, 16'sd0, 16'sd0);
        look(16'd5, 16'd5);

        // Pitch without the clamp saturates to the angle register range.
        write_reg(REG_MOUSE_SENS, 16'hffff);
        write_reg(REG_CONSTRAIN, 16'd0);
        set_world_up(16'sd0, -16'sd16384, 16'sd0);
        look(16'h7fff, 16'h7fff);
        look(16'h7fff, 16'h7fff);
        look(16'h8000, 16'h8000);

        // Phase with the reset-like settings.
        write_reg(REG_MOUSE_SENS, 16'd6554);
        write_reg(REG_MOVE_SPEED, 16'd640);
        write_reg(REG_CONSTRAIN, 16'd1);
        set_world_up(16'sd0, 16'sd16384, 16'sd0);
        random_phase(400, 35, 0);

        // Maximum speed and sensitivity with a drifting walk into saturation.
        write_reg(REG_MOVE_SPEED, 16'hffff);
        write_reg(REG_MOUSE_SENS, 16'hffff);
        random_phase(350, 15, 1);

        // Zero speed and sensitivity, clamp off, world up pointing down z.
        write_reg(REG_MOVE_SPEED, 16'd0);
        write_reg(REG_MOUSE_SENS, 16'd0);
        write_reg(REG_CONSTRAIN, 16'd0);
        set_world_up(16'sd0, 16'sd0, -16'sd16384);
        random_phase(250, 30, 0);

        // Random settings, with an arbitrary non-unit world up.
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_MOVE_SPEED, 16'($urandom));
            write_reg(REG_MOUSE_SENS, 16'($urandom));
            write_reg(REG_CONSTRAIN, 16'($urandom_range(1)));
            set_world_up(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                         16'($urandom_range(32768) - 16384));
            random_phase(280, 35, 0);
        end

        drain_poses();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && poses_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ecp_pkg.sv
rtl/ecp_cordic.sv
rtl/ecp_norm.sv
rtl/euler_camera_pose_update_unit.sv
tb/ecp_checker.sv
tb/tb_euler_camera_pose_update_unit.sv
